/* hdl/qrs_pkg.sv */
// Package for the quadratic root solver: transaction payload types and constants.
// No dependencies; used by quadratic_root_solver, qrs_checker and the testbench.
package qrs_pkg;

    typedef struct packed {
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
    } t_coefs;

    typedef struct packed {
        logic        [1:0]  root_count;
        logic signed [47:0] first_root;
        logic signed [47:0] second_root;
    } t_roots;

    localparam logic [15:0]        TOL_RESET = 16'd7;
    localparam logic signed [47:0] ROOT_MAX  = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ROOT_MIN  = 48'sh8000_0000_0000;
    localparam logic [1:0]         CNT_NONE  = 2'd0;
    localparam logic [1:0]         CNT_ONE   = 2'd1;
    localparam logic [1:0]         CNT_TWO   = 2'd2;

endpackage

/* hdl/quadratic_root_solver.sv */
// Throughput one transaction per cycle while i_out_stall is low. Depth is set by the
// square root (4 result bits per stage, 8 stages) followed by two parallel dividers
// (5 quotient bits per stage, 10 stages).
// Reset (synchronous, active low) clears every stage valid and loads tolerance 7.
// Stages with no valid data fill while later stages are stalled.
module quadratic_root_solver (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  qrs_pkg::t_coefs i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output qrs_pkg::t_roots o_out_data
);
    import qrs_pkg::*;

    // stage map
    localparam int ST_IN    = 0;   // input register
    localparam int ST_PROD  = 1;   // zero tests, b*b and a*c
    localparam int ST_DISC  = 2;   // discriminant, Q34.32
    localparam int ST_CLS   = 3;   // case decode
    localparam int SQ_STG   = 8;
    localparam int SQ_STEP  = 4;
    localparam int ST_SQ0   = 4;
    localparam int ST_NUM   = ST_SQ0 + SQ_STG;   // numerators and divisor
    localparam int ST_MAG   = ST_NUM + 1;        // magnitudes and signs
    localparam int DV_STG   = 10;
    localparam int DV_STEP  = 5;
    localparam int ST_DV0   = ST_MAG + 1;
    localparam int ST_OUT   = ST_DV0 + DV_STG;   // saturation and result register
    localparam int NUM_ST   = ST_OUT + 1;

    typedef enum logic [2:0] {
        CASE_NONE,    // no real root
        CASE_ZERO,    // c and a near zero: root 0
        CASE_CZERO,   // c near zero: roots 0 and -b/a
        CASE_LIN,     // a near zero: -c/b
        CASE_DOUBLE,  // -b/(2a)
        CASE_TWO      // (-b +- s)/(2a)
    } t_case;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic [15:0]        tol;
        logic               za;
        logic               zb;
        logic               zc;
        logic [63:0]        t;
        logic signed [63:0] p;
        logic signed [65:0] d;
        t_case              kase;
        logic [1:0]         rem2;
        logic [63:0]        rad;
        logic [34:0]        sq_rem;
        logic [31:0]        root;
        logic signed [34:0] num1;
        logic signed [34:0] num2;
        logic signed [33:0] den;
        logic [49:0]        dvd1;
        logic [49:0]        dvd2;
        logic [32:0]        dmag;
        logic               neg1;
        logic               neg2;
        logic [33:0]        drem1;
        logic [33:0]        drem2;
        logic [49:0]        q1;
        logic [49:0]        q2;
        t_roots             res;
    } t_stage;

    logic [15:0]       r_tol;
    logic [NUM_ST-1:0] r_v;
    logic [NUM_ST-1:0] adv;
    t_stage            r_pipe [NUM_ST];
    t_stage            n_pipe [NUM_ST];

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [47:0] sat_root(input logic [49:0] q, input logic neg);
        logic signed [47:0] r;
        if (neg) begin
            if (q > 50'h0_8000_0000_0000) r = ROOT_MIN;
            else r = 48'(-$signed(q));
        end else begin
            if (q > 50'h0_7FFF_FFFF_FFFF) r = ROOT_MAX;
            else r = $signed(q[47:0]);
        end
        sat_root = r;
    endfunction

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    // stage k moves when it is empty or stage k+1 moves
    always_comb begin
        adv[NUM_ST-1] = !r_v[NUM_ST-1] || !i_out_stall;
        for (int k = NUM_ST - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_in_stall  = !adv[ST_IN];
    assign o_out_valid = r_v[ST_OUT];
    assign o_out_data  = r_pipe[ST_OUT].res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[ST_IN]) r_v[ST_IN] <= i_in_valid;
            for (int k = 1; k < NUM_ST; k++) begin
                if (adv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_ST; k++) begin
            if (adv[k]) r_pipe[k] <= n_pipe[k];
        end
    end

    // input capture
    always_comb begin
        n_pipe[ST_IN]     = '0;
        n_pipe[ST_IN].a   = i_in_data.coef_a;
        n_pipe[ST_IN].b   = i_in_data.coef_b;
        n_pipe[ST_IN].c   = i_in_data.coef_c;
        n_pipe[ST_IN].tol = r_tol;
    end

    // zero tests and the two products
    always_comb begin
        t_stage s;
        logic signed [63:0] ax, bx, cx;
        s  = r_pipe[ST_IN];
        ax = 64'(s.a);
        bx = 64'(s.b);
        cx = 64'(s.c);
        s.za = mag32(s.a) <= {16'd0, s.tol};
        s.zb = mag32(s.b) <= {16'd0, s.tol};
        s.zc = mag32(s.c) <= {16'd0, s.tol};
        s.t  = bx * bx;
        s.p  = ax * cx;
        n_pipe[ST_PROD] = s;
    end

    // D = b*b - 4*a*c, exact
    always_comb begin
        t_stage s;
        s   = r_pipe[ST_PROD];
        s.d = $signed({2'b00, s.t}) - $signed({s.p, 2'b00});
        n_pipe[ST_DISC] = s;
    end

    // degenerate cases first, then discriminant against tolerance<<16
    always_comb begin
        t_stage s;
        logic signed [65:0] tol_d;
        s     = r_pipe[ST_DISC];
        tol_d = $signed({34'd0, s.tol, 16'd0});
        priority if (s.zc) begin
            s.kase = s.za ? CASE_ZERO : CASE_CZERO;
        end else if (s.za) begin
            s.kase = s.zb ? CASE_NONE : CASE_LIN;
        end else if (s.d < -tol_d) begin
            s.kase = CASE_NONE;
        end else if (s.d <= tol_d) begin
            s.kase = CASE_DOUBLE;
        end else begin
            s.kase = CASE_TWO;
        end
        s.rem2   = s.d[1:0];
        // e = floor(D/4), non-negative in the two-root case
        s.rad    = (s.kase == CASE_TWO) ? s.d[65:2] : 64'd0;
        s.sq_rem = '0;
        s.root   = '0;
        n_pipe[ST_CLS] = s;
    end

    // restoring square root of e, two radicand bits per step
    for (genvar g = 0; g < SQ_STG; g++) begin : g_sqrt
        always_comb begin
            t_stage s;
            logic [34:0] tmp;
            logic [34:0] trial;
            s = r_pipe[ST_SQ0 + g - 1];
            for (int j = 0; j < SQ_STEP; j++) begin
                tmp   = {s.sq_rem[32:0], s.rad[63:62]};
                trial = {1'b0, s.root, 2'b01};
                s.rad = {s.rad[61:0], 2'b00};
                if (tmp >= trial) begin
                    s.sq_rem = tmp - trial;
                    s.root   = {s.root[30:0], 1'b1};
                end else begin
                    s.sq_rem = tmp;
                    s.root   = {s.root[30:0], 1'b0};
                end
            end
            n_pipe[ST_SQ0 + g] = s;
        end
    end

    // s = 2m + 1 when e - m*m - m plus the dropped bits is positive; then numerators
    always_comb begin
        t_stage s;
        logic              bump;
        logic [32:0]       sval;
        logic signed [34:0] nb;
        logic signed [34:0] sx;
        s    = r_pipe[ST_NUM - 1];
        bump = (s.sq_rem > {3'd0, s.root}) ||
               ((s.sq_rem == {3'd0, s.root}) && (s.rem2 != 2'd0));
        sval = {s.root, 1'b0} + 33'(bump);
        nb   = -35'(s.b);
        sx   = $signed({2'b00, sval});
        s.num1 = '0;
        s.num2 = '0;
        s.den  = 34'sd1;
        unique case (s.kase)
            CASE_CZERO: begin
                s.num2 = nb;
                s.den  = 34'(s.a);
            end
            CASE_LIN: begin
                s.num1 = -35'(s.c);
                s.den  = 34'(s.b);
            end
            CASE_DOUBLE: begin
                s.num1 = nb;
                s.den  = $signed({s.a[31], s.a, 1'b0});
            end
            CASE_TWO: begin
                s.num1 = nb + sx;
                s.num2 = nb - sx;
                s.den  = $signed({s.a[31], s.a, 1'b0});
            end
            default: begin
            end
        endcase
        n_pipe[ST_NUM] = s;
    end

    // magnitudes, quotient signs, dividends scaled by 2^16
    always_comb begin
        t_stage s;
        logic [33:0] m1, m2;
        s       = r_pipe[ST_NUM];
        m1      = s.num1[34] ? 34'(-s.num1) : 34'(s.num1);
        m2      = s.num2[34] ? 34'(-s.num2) : 34'(s.num2);
        s.dmag  = s.den[33] ? 33'(-s.den) : 33'(s.den);
        s.neg1  = s.num1[34] ^ s.den[33];
        s.neg2  = s.num2[34] ^ s.den[33];
        s.dvd1  = {m1, 16'd0};
        s.dvd2  = {m2, 16'd0};
        s.drem1 = '0;
        s.drem2 = '0;
        s.q1    = '0;
        s.q2    = '0;
        n_pipe[ST_MAG] = s;
    end

    // two restoring dividers side by side, one quotient bit per step
    for (genvar g = 0; g < DV_STG; g++) begin : g_div
        always_comb begin
            t_stage s;
            logic [33:0] t1, t2;
            s = r_pipe[ST_DV0 + g - 1];
            for (int j = 0; j < DV_STEP; j++) begin
                t1     = {s.drem1[32:0], s.dvd1[49]};
                t2     = {s.drem2[32:0], s.dvd2[49]};
                s.dvd1 = {s.dvd1[48:0], 1'b0};
                s.dvd2 = {s.dvd2[48:0], 1'b0};
                if (t1 >= {1'b0, s.dmag}) begin
                    s.drem1 = t1 - {1'b0, s.dmag};
                    s.q1    = {s.q1[48:0], 1'b1};
                end else begin
                    s.drem1 = t1;
                    s.q1    = {s.q1[48:0], 1'b0};
                end
                if (t2 >= {1'b0, s.dmag}) begin
                    s.drem2 = t2 - {1'b0, s.dmag};
                    s.q2    = {s.q2[48:0], 1'b1};
                end else begin
                    s.drem2 = t2;
                    s.q2    = {s.q2[48:0], 1'b0};
                end
            end
            n_pipe[ST_DV0 + g] = s;
        end
    end

    // sign, saturation, count; unused roots read zero
    always_comb begin
        t_stage s;
        logic signed [47:0] r1, r2;
        s  = r_pipe[ST_OUT - 1];
        r1 = sat_root(s.q1, s.neg1);
        r2 = sat_root(s.q2, s.neg2);
        s.res = '0;
        unique case (s.kase)
            CASE_NONE: begin
                s.res.root_count = CNT_NONE;
            end
            CASE_ZERO: begin
                s.res.root_count = CNT_ONE;
            end
            CASE_CZERO: begin
                s.res.root_count  = CNT_TWO;
                s.res.second_root = r2;
            end
            CASE_LIN, CASE_DOUBLE: begin
                s.res.root_count = CNT_ONE;
                s.res.first_root = r1;
            end
            CASE_TWO: begin
                s.res.root_count  = CNT_TWO;
                s.res.first_root  = r1;
                s.res.second_root = r2;
            end
            default: begin
                s.res.root_count = CNT_NONE;
            end
        endcase
        n_pipe[ST_OUT] = s;
    end

endmodule

/* hdl/qrs_checker.sv */
// Port-level checks for quadratic_root_solver, attached by bind.
// Depends on qrs_pkg for the transaction payload types.
module qrs_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_cfg_we,
    input logic [15:0]     i_cfg_data,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input qrs_pkg::t_coefs i_in_data,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input qrs_pkg::t_roots o_out_data
);
    import qrs_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.root_count != 2'd3)
        else $error("root count out of range");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.root_count == CNT_NONE |->
            o_out_data.first_root == '0 && o_out_data.second_root == '0)
        else $error("roots not zero with no root");

    a_one_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.root_count == CNT_ONE |-> o_out_data.second_root == '0)
        else $error("second root not zero with one root");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);

/* tb/quadratic_root_solver_tb.sv */
// Testbench for quadratic_root_solver: directed table, then random coefficient sets
// over several tolerance settings, each result checked against a hand-derived expectation or a local root solver.
// Depends on qrs_pkg (payload structs and constants) and the DUT.
module quadratic_root_solver_tb;
    import qrs_pkg::*;

    localparam int  PHASE_ITEMS   = 300;
    localparam int  DRAIN_CYCLES  = 40;
    localparam int  WATCHDOG_MAX  = 5000;  // idle cycles before giving up
    localparam longint ONE        = 65536; // 1.0 in Q16.16
    localparam longint BIG_DISC   = longint'(1) << 61;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic    i_in_valid = 1'b0;
    logic    o_in_stall;
    t_coefs  i_in_data = '0;
    logic    o_out_valid;
    logic    i_out_stall = 1'b0;
    t_roots  o_out_data;

    // Expected roots in acceptance order, tolerance as the DUT holds it.
    t_roots      roots_due[$];
    logic [15:0] tol_now = TOL_RESET;
    int          mismatches = 0;
    int          idle_cycles = 0;

    // Directed rows; typed rows carry a hand-derived expectation.
    typedef struct {
        t_coefs coefs;
        bit     typed;
        t_roots roots;
    } t_row;
    t_row table_rows[$];

    quadratic_root_solver DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // ---------------- root solver (bit exact) ----------------

    function automatic bit is_small(longint v, longint tol);
        return ((v < 0) ? -v : v) <= tol;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, pos;
        r   = 0;
        pos = longint'(1) << 62;
        while (pos > v) pos >>= 2;
        while (pos != 0) begin
            if (v >= r + pos) begin
                v -= r + pos;
                r = (r >> 1) + pos;
            end else begin
                r >>= 1;
            end
            pos >>= 2;
        end
        return r;
    endfunction

    // Q16.16 over Q16.16 -> Q32.16, truncated toward zero, saturated to 48 bits.
    function automatic logic signed [47:0] sat_div(longint num, longint den);
        longint q;
        q = (num * 65536) / den;
        if (q > longint'(ROOT_MAX)) q = ROOT_MAX;
        if (q < longint'(ROOT_MIN)) q = ROOT_MIN;
        return q[47:0];
    endfunction

    function automatic t_roots solve_roots(t_coefs x, logic [15:0] tol_reg);
        longint a, b, c, tol, e, p, m, k, s;
        longint unsigned sq, rem, tol_d, ne;
        int     kind;
        t_roots r;
        a = x.coef_a;
        b = x.coef_b;
        c = x.coef_c;
        tol = tol_reg;
        tol_d = longint'(tol_reg) << 16;
        r = '0;
        if (is_small(c, tol)) begin
            if (is_small(a, tol)) begin
                r.root_count = CNT_ONE;
            end else begin
                r.root_count  = CNT_TWO;
                r.second_root = sat_div(-b, a);
            end
        end else if (is_small(a, tol)) begin
            if (!is_small(b, tol)) begin
                r.root_count = CNT_ONE;
                r.first_root = sat_div(-c, b);
            end
        end else begin
            // D = b*b - 4ac written as 4e + rem, rem in 0..3
            sq  = b * b;
            p   = a * c;
            e   = longint'(sq >> 2) - p;
            rem = sq & 3;
            if (e < 0) begin
                ne = -e;
                kind = (ne >= BIG_DISC || 4 * ne - rem > tol_d) ? 0 : 1;
            end else if (e >= BIG_DISC) begin
                kind = 2;
            end else begin
                kind = (4 * longint'(e) + rem <= tol_d) ? 1 : 2;
            end
            if (kind == 1) begin
                r.root_count = CNT_ONE;
                r.first_root = sat_div(-b, 2 * a);
            end else if (kind == 2) begin
                m = int_sqrt(e);
                k = e - m * m - m;
                s = 2 * m + ((4 * k + longint'(rem) >= 1) ? 1 : 0);
                r.root_count  = CNT_TWO;
                r.first_root  = sat_div(-b + s, 2 * a);
                r.second_root = sat_div(-b - s, 2 * a);
            end
        end
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic t_coefs mk(longint a, longint b, longint c);
        t_coefs x;
        x.coef_a = a[31:0];
        x.coef_b = b[31:0];
        x.coef_c = c[31:0];
        return x;
    endfunction

    function automatic logic signed [31:0] edge_value();
        case ($urandom_range(0, 6))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 0;
            3: return 1;
            4: return -1;
            5: return 32'($urandom_range(0, 1) ? ONE : -ONE);
            default: return $urandom;
        endcase
    endfunction

    // Value inside or just outside the zero band.
    function automatic longint near_band();
        longint span;
        span = longint'(tol_now) + 3;
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    function automatic t_coefs next_coefs();
        longint ai, r1, r2;
        ai = longint'($urandom_range(1, 40)) * ($urandom_range(0, 1) ? 1 : -1);
        r1 = longint'($urandom_range(0, 40)) - 20;
        r2 = longint'($urandom_range(0, 40)) - 20;
        case ($urandom_range(0, 9))
            // factored from integer roots: exercises the two-root path
            0, 1, 2: return mk(ai * ONE, -ai * (r1 + r2) * ONE, ai * r1 * r2 * ONE);
            3:       return mk(ai * ONE, -2 * ai * r1 * ONE, ai * r1 * r1 * ONE);
            4:       return mk($signed($urandom), $signed($urandom), $signed($urandom));
            5:       return mk(near_band(), near_band(), near_band());
            6:       return mk(edge_value(), edge_value(), edge_value());
            7:       return mk($signed($urandom), $signed($urandom), near_band());
            8:       return mk(near_band(), ($urandom_range(0, 1) ? near_band()
                                              : longint'($signed($urandom))),
                               $signed($urandom));
            default: return mk(longint'($urandom_range(0, 65535)) - 32768,
                               longint'($urandom_range(0, 65535)) - 32768,
                               longint'($urandom_range(0, 65535)) - 32768);
        endcase
    endfunction

    function automatic t_roots roots(logic [1:0] n, longint r1, longint r2);
        t_roots r;
        r.root_count  = n;
        r.first_root  = r1[47:0];
        r.second_root = r2[47:0];
        return r;
    endfunction

    // ---------------- driving (falling edge) ----------------

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_coefs(t_coefs x, bit typed, t_roots want);
        i_in_valid <= 1'b1;
        i_in_data  <= x;
        do @(posedge i_clk); while (o_in_stall);
        roots_due.push_back(typed ? want : solve_roots(x, tol_now));
        @(negedge i_clk);
    endtask

    // Burst/gap pacing for the sender; some bursts are very long (no idling).
    int burst_left = 0;
    task automatic sender_pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(0, 12);
        gap = $urandom_range(1, 6);
        i_in_valid <= 1'b0;
        repeat (gap) @(negedge i_clk);
    endtask

    // Wait until every expected result has come, then let the pipe settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (roots_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tolerance(logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        tol_now  = v;
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // ---------------- receiver stall pattern ----------------

    int stall_mode = 0;
    int stall_tick = 0;
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 97 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_tick % 3 == 0);
        endcase
    end

    // ---------------- checking and watchdog (rising edge) ----------------

    always @(posedge i_clk) begin
        t_roots want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (roots_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", o_out_data);
            end else begin
                want = roots_due.pop_front();
                if (o_out_data.root_count !== want.root_count
                        || o_out_data.first_root !== want.first_root
                        || o_out_data.second_root !== want.second_root) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                 want.root_count, want.first_root, want.second_root,
                                 o_out_data.root_count, o_out_data.first_root,
                                 o_out_data.second_root);
                end
            end
        end
        if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        logic [15:0] tol_list [6];
        t_row row;
        tol_list = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd7, 16'd0};
        tol_list[3] = 16'($urandom_range(2, 65534));

        // Typed rows: hand-checked at the reset tolerance of 7.
        table_rows.push_back('{mk(0, 0, 0), 1, roots(CNT_ONE, 0, 0)});
        table_rows.push_back('{mk(ONE, 0, 0), 1, roots(CNT_TWO, 0, 0)});
        table_rows.push_back('{mk(0, 0, ONE), 1, roots(CNT_NONE, 0, 0)});
        table_rows.push_back('{mk(0, ONE, -2 * ONE), 1, roots(CNT_ONE, 2 * ONE, 0)});
        table_rows.push_back('{mk(ONE, 0, -ONE), 1, roots(CNT_TWO, ONE, -ONE)});
        table_rows.push_back('{mk(ONE, -2 * ONE, ONE), 1, roots(CNT_ONE, ONE, 0)});
        table_rows.push_back('{mk(ONE, 0, ONE), 1, roots(CNT_NONE, 0, 0)});
        table_rows.push_back('{mk(7, 7, 7), 1, roots(CNT_ONE, 0, 0)});
        table_rows.push_back('{mk(8, 8, 7), 1, roots(CNT_TWO, 0, -ONE)});
        table_rows.push_back('{mk(7, 7, 8), 1, roots(CNT_NONE, 0, 0)});
        // Predicted rows: extremes, edges of the band, saturation.
        table_rows.push_back('{mk(-2147483648, -2147483648, -2147483648), 0, '0});
        table_rows.push_back('{mk(2147483647, 2147483647, 2147483647), 0, '0});
        table_rows.push_back('{mk(-2147483648, 2147483647, 2147483647), 0, '0});
        table_rows.push_back('{mk(2147483647, -2147483648, -2147483648), 0, '0});
        table_rows.push_back('{mk(0, 8, -2147483648), 0, '0});
        table_rows.push_back('{mk(8, -2147483648, 0), 0, '0});
        table_rows.push_back('{mk(8, 2147483647, 2147483647), 0, '0});
        table_rows.push_back('{mk(-8, 0, 2147483647), 0, '0});
        table_rows.push_back('{mk(8, 0, -2147483648), 0, '0});
        table_rows.push_back('{mk(ONE, 4, 0), 0, '0});
        table_rows.push_back('{mk(3 * ONE, ONE, -5 * ONE), 0, '0});
        table_rows.push_back('{mk(-8, -2147483648, -8), 0, '0});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (table_rows[i]) begin
            row = table_rows[i];
            send_coefs(row.coefs, row.typed, row.roots);
            sender_pace();
        end
        drain();

        // Random phases, one tolerance each; the drain before each write
        // also makes the sender hold off until all results are back.
        foreach (tol_list[p]) begin
            write_tolerance(tol_list[p]);
            repeat (PHASE_ITEMS) begin
                send_coefs(next_coefs(), 0, '0);
                sender_pace();
            end
            drain();
        end

        if (roots_due.size() == 0 && mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
hdl/qrs_pkg.sv
hdl/quadratic_root_solver.sv
hdl/qrs_checker.sv
tb/quadratic_root_solver_tb.sv
